@@ src/key_press_classifier_unit_assert.svh @@
// Assertion macros for the key press classifier checks.
`ifndef KEY_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define KEY_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define KPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key press classifier check failed");

// Next-cycle implication, disabled while reset is applied.
`define KPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key press classifier check failed");

`endif

@@ src/kpc_pkg.sv @@
// Shared types, codes and constants of the key press classifier.
package kpc_pkg;

    localparam int KEY_COUNT    = 4;
    localparam int LEVELS_W     = 4;
    localparam int SEL_W        = 2;
    localparam int FUNC_W       = 2;
    localparam int STATE_W      = 2;
    localparam int TICK_W       = 32;
    localparam int CNT_W        = 16;
    localparam int PACKED_KEYS  = 4;
    localparam int ALL_STATES_W = PACKED_KEYS * STATE_W;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [CNT_W-1:0]  HELD_MAX        = 16'hFFFF;
    localparam logic [TICK_W-1:0] LAST_TICK_RESET = 32'hFFFF_FFFF;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_LEVEL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WINDOW = 3'd4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_READ      = 2'd1,
        FUNC_CLEAR_ONE = 2'd2,
        FUNC_CLEAR_ALL = 2'd3
    } func_t;

    typedef enum logic [STATE_W-1:0] {
        ST_RELEASE = 2'd0,
        ST_SINGLE  = 2'd1,
        ST_DOUBLE  = 2'd2,
        ST_LONG    = 2'd3
    } press_t;

    typedef struct packed {
        logic             release_level;
        logic [CNT_W-1:0] long_press_ticks;
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] short_limit;
        logic [CNT_W-1:0] double_window_ticks;
    } kpc_cfg_t;

    typedef struct packed {
        logic              scan;
        logic              clear_one;
        logic              clear_all;
        logic [TICK_W-1:0] tick_now;
    } kpc_cmd_t;

endpackage

@@ src/kpc_key_cell.sv @@
// State and next-state logic of one key: held count, class and last release tick.
module kpc_key_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  kpc_pkg::kpc_cmd_t cmd,
    input  kpc_pkg::kpc_cfg_t cfg,
    input  logic              level,
    input  logic              selected,
    output kpc_pkg::press_t   state_next
);
    import kpc_pkg::*;

    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  held_next;
    press_t            state_reg;
    logic [TICK_W-1:0] last_reg;
    logic [TICK_W-1:0] last_next;
    logic [CNT_W-1:0]  held_inc;
    logic [TICK_W-1:0] since;
    logic              short_press;
    logic              in_window;

    // Saturating held count and modular distance to the last single release
    assign held_inc    = (held_reg == HELD_MAX) ? held_reg : held_reg + CNT_W'(1);
    assign since       = cmd.tick_now - last_reg;
    assign in_window   = since <= {{(TICK_W-CNT_W){1'b0}}, cfg.double_window_ticks};
    assign short_press = (held_reg >= cfg.debounce_ticks) && (held_reg < cfg.short_limit);

    // Classify on a scan tick, otherwise apply clears
    always_comb
    begin
        held_next  = held_reg;
        state_next = state_reg;
        last_next  = last_reg;
        if (cmd.scan)
        begin
            if (level != cfg.release_level)
            begin
                held_next = held_inc;
                if (held_inc >= cfg.long_press_ticks)
                begin
                    state_next = ST_LONG;
                end
            end
            else if (state_reg == ST_LONG)
            begin
                held_next  = '0;
                state_next = ST_RELEASE;
            end
            else
            begin
                held_next = '0;
                if (short_press && in_window)
                begin
                    state_next = ST_DOUBLE;
                    last_next  = '0;
                end
                else if (short_press)
                begin
                    state_next = ST_SINGLE;
                    last_next  = cmd.tick_now;
                end
                else
                begin
                    state_next = ST_RELEASE;
                end
            end
        end
        else if (cmd.clear_all || (cmd.clear_one && selected))
        begin
            state_next = ST_RELEASE;
        end
    end

    // Hold the key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            state_reg <= ST_RELEASE;
            last_reg  <= LAST_TICK_RESET;
        end
        else
        begin
            held_reg  <= held_next;
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

endmodule

@@ src/key_press_classifier_unit.sv @@
// Top level of the key press classifier: stream ports, configuration, tick counter, result.
//
//  channel   direction  handshake             payload
//  s_axis    in         tvalid/tready         tuser: func; tdata: key_levels, key_select
//  m_axis    out        tvalid/tready         tdata: all_states, selected_state
//  cfg       in         cfg_we (no wait)      cfg_index, cfg_data
//
// An item is registered on acceptance and its result is loaded into the output register
// when the item advances; one item per cycle is sustained while the output is not stalled,
// set by the single update stage between the two registers. A stalled result holds in the
// output register while one more item waits in the input register. Reset (rst_n low,
// asynchronous) clears the pipeline, tick counter, all key state and resets configuration.
module key_press_classifier_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] key_levels, [5:4] key_select, [7:6] zero
    input  logic [1:0] s_axis_tuser,   // [1:0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] all_states, [9:8] selected_state, [15:10] zero
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import kpc_pkg::*;

    `include "key_press_classifier_unit_assert.svh"

    logic                    in_valid_reg;
    logic                    in_valid_next;
    func_t                   in_func_reg;
    logic [LEVELS_W-1:0]     in_levels_reg;
    logic [SEL_W-1:0]        in_sel_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [ALL_STATES_W-1:0] out_states_reg;
    logic [STATE_W-1:0]      out_sel_reg;
    logic [TICK_W-1:0]       tick_reg;
    logic [TICK_W-1:0]       tick_next;
    kpc_cfg_t                cfg_reg;
    kpc_cmd_t                cmd;
    logic                    in_accept;
    logic                    advance;
    press_t                  cell_state [KEY_COUNT];
    logic [ALL_STATES_W-1:0] all_states;
    press_t                  sel_state;

    // Handshake: an item moves on when the output register is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Command to the key cells
    assign tick_next     = tick_reg + TICK_W'(1);
    assign cmd.scan      = advance && (in_func_reg == FUNC_TICK);
    assign cmd.clear_one = advance && (in_func_reg == FUNC_CLEAR_ONE);
    assign cmd.clear_all = advance && (in_func_reg == FUNC_CLEAR_ALL);
    assign cmd.tick_now  = tick_next;

    // One cell per key
    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_key
        logic level_bit;
        if (k < LEVELS_W)
        begin : g_pin
            assign level_bit = in_levels_reg[k];
        end
        else
        begin : g_no_pin
            assign level_bit = 1'b0;
        end
        kpc_key_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .cfg        (cfg_reg),
            .level      (level_bit),
            .selected   (int'(in_sel_reg) == k),
            .state_next (cell_state[k])
        );
    end

    // Pack the updated states and pick the selected key
    always_comb
    begin
        all_states = '0;
        sel_state  = ST_RELEASE;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            if (k < PACKED_KEYS)
            begin
                all_states[STATE_W*k +: STATE_W] = cell_state[k];
            end
            if (int'(in_sel_reg) == k)
            begin
                sel_state = cell_state[k];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cmd.scan)
            begin
                tick_reg <= tick_next;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_level       <= 1'b1;
            cfg_reg.long_press_ticks    <= CNT_W'(100);
            cfg_reg.debounce_ticks      <= CNT_W'(2);
            cfg_reg.short_limit         <= CNT_W'(1000);
            cfg_reg.double_window_ticks <= CNT_W'(20);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RELEASE_LEVEL: cfg_reg.release_level       <= cfg_data[0];
                REG_LONG_PRESS:    cfg_reg.long_press_ticks    <= cfg_data[CNT_W-1:0];
                REG_DEBOUNCE:      cfg_reg.debounce_ticks      <= cfg_data[CNT_W-1:0];
                REG_SHORT_LIMIT:   cfg_reg.short_limit         <= cfg_data[CNT_W-1:0];
                REG_DOUBLE_WINDOW: cfg_reg.double_window_ticks <= cfg_data[CNT_W-1:0];
                default:           cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    // Payload registers: load the item on acceptance, the result on advance
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_func_reg   <= func_t'(s_axis_tuser);
            in_levels_reg <= s_axis_tdata[LEVELS_W-1:0];
            in_sel_reg    <= s_axis_tdata[LEVELS_W +: SEL_W];
        end
        if (advance)
        begin
            out_states_reg <= all_states;
            out_sel_reg    <= sel_state;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-ALL_STATES_W-STATE_W){1'b0}}, out_sel_reg,
                            out_states_reg};

    // Checks on the pipeline and tick counter
    `KPC_ASSERT_NEXT(a_advance_fills_output, clk, rst_n, advance, m_axis_tvalid)
    `KPC_ASSERT_NEXT(a_waiting_item_holds, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(in_func_reg) && $stable(in_sel_reg))
    `KPC_ASSERT_NEXT(a_tick_only_on_scan, clk, rst_n, !cmd.scan, $stable(tick_reg))
    `KPC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !in_valid_reg, s_axis_tready)

endmodule

@@ verif/key_press_classifier_unit_tb.sv @@
// Self-checking testbench for the key press classifier: stream stimulus, result checking.
`timescale 1ns / 1ps

module key_press_classifier_unit_tb;
    import kpc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_TICKS  = 120;

    typedef struct packed {
        logic [ALL_STATES_W-1:0] all_states;
        logic [STATE_W-1:0]      selected_state;
    } key_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [3:0] key_levels, [5:4] key_select, [7:6] zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] all_states, [9:8] selected_state, [15:10] zero
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Own copy of the classifier state and timing registers
    kpc_cfg_t          timing;
    logic [TICK_W-1:0] scan_ticks;
    logic [CNT_W-1:0]  held_ticks [KEY_COUNT];
    press_t            model_state [KEY_COUNT];
    logic [TICK_W-1:0] single_tick [KEY_COUNT];

    // Stimulus model of the buttons: each key alternates held and released stretches
    bit  key_down [KEY_COUNT];
    int  stretch_left [KEY_COUNT];

    key_report_t pending_reports[$];
    int  src_gap_pct = 0;
    int  sink_gap_pct = 0;
    bit  hold_rx = 1'b0;
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  reports_checked = 0;
    int  timing_sets = 0;
    int  stall_cycles = 0;

    key_press_classifier_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Apply one item to the state copy and return the report it produces
    function automatic key_report_t classify_item(func_t f, logic [3:0] lv, logic [1:0] sel);
        key_report_t       r;
        logic [TICK_W-1:0] since;
        case (f)
            FUNC_TICK:
            begin
                scan_ticks = scan_ticks + 32'd1;
                for (int i = 0; i < KEY_COUNT; i++)
                begin
                    if (lv[i] != timing.release_level)
                    begin
                        if (held_ticks[i] != HELD_MAX)
                            held_ticks[i] = held_ticks[i] + 16'd1;
                        if (held_ticks[i] >= timing.long_press_ticks)
                            model_state[i] = ST_LONG;
                    end
                    else if (model_state[i] == ST_LONG)
                    begin
                        held_ticks[i] = '0;
                        model_state[i] = ST_RELEASE;
                    end
                    else
                    begin
                        if (held_ticks[i] >= timing.debounce_ticks &&
                            held_ticks[i] < timing.short_limit)
                        begin
                            since = scan_ticks - single_tick[i];
                            if (since <= {16'd0, timing.double_window_ticks})
                            begin
                                model_state[i] = ST_DOUBLE;
                                single_tick[i] = '0;
                            end
                            else
                            begin
                                model_state[i] = ST_SINGLE;
                                single_tick[i] = scan_ticks;
                            end
                        end
                        else
                            model_state[i] = ST_RELEASE;
                        held_ticks[i] = '0;
                    end
                end
            end
            FUNC_CLEAR_ONE: model_state[sel] = ST_RELEASE;
            FUNC_CLEAR_ALL:
                for (int i = 0; i < KEY_COUNT; i++)
                    model_state[i] = ST_RELEASE;
            default: ;
        endcase
        for (int i = 0; i < PACKED_KEYS; i++)
            r.all_states[2*i +: 2] = model_state[i];
        r.selected_state = model_state[sel];
        return r;
    endfunction

    // Length of the next held stretch, spread around the thresholds
    function automatic int pick_hold();
        int d;
        case ($urandom_range(3))
            0: d = $urandom_range(0, int'(timing.debounce_ticks) + 1);
            1: d = $urandom_range(int'(timing.debounce_ticks), int'(timing.short_limit));
            2: d = $urandom_range(int'(timing.long_press_ticks) - 1,
                                  int'(timing.long_press_ticks) + 2);
            default: d = $urandom_range(1, 8);
        endcase
        if (d < 1)
            d = 1;
        if (d > 60)
            d = $urandom_range(40, 60);
        return d;
    endfunction

    // Advance the button model by one scan and return the pin levels
    function automatic logic [3:0] next_levels();
        logic [3:0] lv;
        int         d;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (stretch_left[i] == 0)
            begin
                key_down[i] = !key_down[i];
                if (key_down[i])
                    d = pick_hold();
                else
                    d = $urandom_range(1, int'(timing.double_window_ticks) + 3);
                if (d > 60)
                    d = $urandom_range(40, 60);
                stretch_left[i] = d;
            end
            stretch_left[i]--;
            lv[i] = key_down[i] ? ~timing.release_level : timing.release_level;
        end
        return lv;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // Offer one item, hold it until accepted, then record its expected report
    task automatic send_item(func_t f, logic [3:0] lv, logic [1:0] sel);
        if ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, sel, lv};
        s_axis_tuser  <= f;
        do @(posedge clk); while (!s_axis_tready);
        pending_reports.push_back(classify_item(f, lv, sel));
        items_sent++;
    endtask

    // Drop valid and wait until every report has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all five timing registers back to back; the block is idle here
    task automatic program_timings(kpc_cfg_t c);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_INDEX_W-1:0] idx [5];
        vals = '{{15'd0, c.release_level}, c.long_press_ticks, c.debounce_ticks,
                 c.short_limit, c.double_window_ticks};
        idx  = '{REG_RELEASE_LEVEL, REG_LONG_PRESS, REG_DEBOUNCE, REG_SHORT_LIMIT,
                 REG_DOUBLE_WINDOW};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        timing = c;
        timing_sets++;
    endtask

    // Mostly button traffic, with reads, clears and noisy scans mixed in
    task automatic run_key_traffic(int n);
        int r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 75)
                send_item(FUNC_TICK, next_levels(), 2'($urandom_range(3)));
            else if (r < 85)
                send_item(FUNC_READ, 4'($urandom_range(15)), 2'($urandom_range(3)));
            else if (r < 90)
                send_item(FUNC_CLEAR_ONE, 4'($urandom_range(15)), 2'($urandom_range(3)));
            else if (r < 93)
                send_item(FUNC_CLEAR_ALL, 4'($urandom_range(15)), 2'($urandom_range(3)));
            else
                send_item(FUNC_TICK, 4'($urandom_range(15)), 2'($urandom_range(3)));
        end
    endtask

    // Hand-picked sequence: single, double, debounce reject, long, short limit, clears
    task automatic test_directed();
        program_timings('{release_level: 1'b1, long_press_ticks: 16'd5, debounce_ticks: 16'd2,
                          short_limit: 16'd3, double_window_ticks: 16'd3});
        send_item(FUNC_TICK, 4'hF, 2'd0);
        for (int s = 0; s < KEY_COUNT; s++)
            send_item(FUNC_READ, 4'($urandom_range(15)), 2'(s));
        repeat (2) send_item(FUNC_TICK, 4'hE, 2'd0);
        send_item(FUNC_TICK, 4'hF, 2'd0);
        repeat (2) send_item(FUNC_TICK, 4'hE, 2'd0);
        send_item(FUNC_TICK, 4'hF, 2'd0);
        send_item(FUNC_CLEAR_ONE, 4'h0, 2'd0);
        send_item(FUNC_TICK, 4'hD, 2'd1);
        send_item(FUNC_TICK, 4'hF, 2'd1);
        repeat (4) send_item(FUNC_TICK, 4'h3, 2'd2);
        send_item(FUNC_TICK, 4'hB, 2'd3);
        send_item(FUNC_READ, 4'h0, 2'd2);
        send_item(FUNC_CLEAR_ALL, 4'hF, 2'd3);
        send_item(FUNC_TICK, 4'h0, 2'd3);
        send_item(FUNC_TICK, 4'hF, 2'd1);
        settle();
    endtask

    // Timing registers at their lowest and highest values
    task automatic test_threshold_extremes();
        program_timings('{release_level: 1'b0, long_press_ticks: 16'd1, debounce_ticks: 16'd0,
                          short_limit: 16'd1, double_window_ticks: 16'd0});
        run_key_traffic(60);
        settle();
        program_timings('{release_level: 1'b1, long_press_ticks: 16'hFFFF,
                          debounce_ticks: 16'hFFFF, short_limit: 16'hFFFF,
                          double_window_ticks: 16'hFFFF});
        run_key_traffic(60);
        settle();
        program_timings('{release_level: 1'b0, long_press_ticks: 16'hFFFF, debounce_ticks: 16'd0,
                          short_limit: 16'hFFFF, double_window_ticks: 16'hFFFF});
        run_key_traffic(60);
        settle();
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        program_timings('{release_level: 1'b1, long_press_ticks: 16'd6, debounce_ticks: 16'd1,
                          short_limit: 16'd4, double_window_ticks: 16'd5});
        src_gap_pct = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (60) @(posedge clk);
                hold_rx <= 1'b0;
            end
            run_key_traffic(30);
        join
        settle();
    endtask

    // Hold one key for a long stretch, then let it go
    task automatic test_long_hold();
        program_timings('{release_level: 1'b1, long_press_ticks: 16'hFFFF, debounce_ticks: 16'd0,
                          short_limit: 16'hFFFF, double_window_ticks: 16'd20});
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        repeat (HOLD_TICKS)
            send_item(FUNC_TICK, 4'hE, 2'($urandom_range(3)));
        send_item(FUNC_TICK, 4'hF, 2'd0);
        send_item(FUNC_READ, 4'hF, 2'd0);
        settle();
    endtask

    // Random timings in small ranges; three idling regimes
    task automatic test_random_traffic();
        int gaps [3][2];
        gaps = '{'{15, 82}, '{82, 15}, '{0, 0}};
        for (int p = 0; p < 3; p++)
        begin
            src_gap_pct  = gaps[p][0];
            sink_gap_pct = gaps[p][1];
            program_timings('{release_level: 1'($urandom_range(1)),
                              long_press_ticks: 16'($urandom_range(1, 24)),
                              debounce_ticks: 16'($urandom_range(0, 6)),
                              short_limit: 16'($urandom_range(1, 20)),
                              double_window_ticks: 16'($urandom_range(0, 12))});
            run_key_traffic(170);
            settle();
        end
    endtask

    // Receiver readiness
    always @(posedge clk)
        m_axis_tready <= hold_rx ? 1'b0 : ($urandom_range(99) >= sink_gap_pct);

    // Compare each accepted report with the oldest expectation
    always @(posedge clk)
    begin
        key_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reports.size() == 0)
                note_mismatch("unexpected report", 0, m_axis_tdata);
            else
            begin
                want = pending_reports.pop_front();
                reports_checked++;
                if (m_axis_tdata[7:0] !== want.all_states)
                    note_mismatch("all_states", want.all_states, m_axis_tdata[7:0]);
                if (m_axis_tdata[9:8] !== want.selected_state)
                    note_mismatch("selected_state", want.selected_state, m_axis_tdata[9:8]);
            end
        end
    end

    // Watchdog: end the run if work is outstanding and nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (!s_axis_tvalid && pending_reports.size() == 0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        // Reset values of the state copy
        timing = '{release_level: 1'b1, long_press_ticks: 16'd100, debounce_ticks: 16'd2,
                   short_limit: 16'd1000, double_window_ticks: 16'd20};
        scan_ticks = '0;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            held_ticks[i]   = '0;
            model_state[i]  = ST_RELEASE;
            single_tick[i]  = LAST_TICK_RESET;
            key_down[i]     = 1'b0;
            stretch_left[i] = 0;
        end
        src_gap_pct  = 15;
        sink_gap_pct = 82;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_threshold_extremes();
        test_output_backpressure();
        src_gap_pct  = 15;
        sink_gap_pct = 82;
        test_long_hold();
        test_random_traffic();

        $display("Checked %0d reports for %0d items across %0d timing settings, %0d mismatches.",
                 reports_checked, items_sent, timing_sets, mismatch_count);
        $display("Scans, reads and clears ran under idling, output hold-off and a %0d-tick hold.",
                 HOLD_TICKS);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
